[design/cfpg_pkg.sv]
// ----------------------------------------------------------------------------
// cfpg_pkg
// Shared types, constants and the PEC update function of the configuration
// frame generator.
// ----------------------------------------------------------------------------
package cfpg_pkg;

	localparam logic [7:0] PEC_SEED  = 8'h41;
	localparam logic [7:0] PEC_POLY  = 8'h07;
	localparam logic [7:0] ADDR_BASE = 8'h80;
	localparam logic [7:0] ZERO_BYTE = 8'h00;

	localparam int unsigned ADDR_CMP_W = 5;
	localparam logic [ADDR_CMP_W-1:0] ADDRESSED_BOARDS = 5'd3;

	localparam int unsigned CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WRITE_COMMAND = 3'd0,
		REG_MODE          = 3'd1,
		REG_UNDERVOLT     = 3'd2,
		REG_OVERVOLT      = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] write_command_code;
		logic [7:0] mode_byte;
		logic [7:0] undervolt_code;
		logic [7:0] overvolt_code;
	} cfg_t;

	typedef struct packed {
		logic        addressed;
		logic [1:0]  board_address;
		logic [11:0] discharge_mask;
	} req_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_CMD,
		SEQ_CMD_PEC,
		SEQ_ADDR,
		SEQ_ADDR_PEC,
		SEQ_MODE,
		SEQ_MASK_LO,
		SEQ_MASK_HI,
		SEQ_ZERO,
		SEQ_UNDERVOLT,
		SEQ_OVERVOLT,
		SEQ_PEC
	} seq_state_t;

	// CRC-8 over one byte, most significant bit first, no final inversion.
	function automatic logic [7:0] pec_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = data[i] ^ c[7];
			c  = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ PEC_POLY;
			end
		end
		return c;
	endfunction

endpackage

[design/cfpg_front.sv]
// ----------------------------------------------------------------------------
// cfpg_front
// Accepts requests, marks whether the board is addressed or broadcast, and
// holds them in a short queue for the frame sequencer.
// ----------------------------------------------------------------------------
module cfpg_front
	import cfpg_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  board_address,
	input  logic [11:0] discharge_mask,
	output logic        req_valid,
	input  logic        req_ready,
	output req_t        req
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	req_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;
	req_t             new_req;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign req_valid = (count_q != '0);
	assign push_ok   = push & ~full;
	assign pop_ok    = req_valid & req_ready;
	assign req       = mem_q[rd_ptr_q];

	always_comb begin
		new_req.addressed      = ({{(ADDR_CMP_W-2){1'b0}}, board_address} < ADDRESSED_BOARDS);
		new_req.board_address  = board_address;
		new_req.discharge_mask = discharge_mask;
	end

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= new_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop_ok) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/cfpg_back.sv]
// ----------------------------------------------------------------------------
// cfpg_back
// Frame sequencer: walks one request through its frame bytes, accumulates
// the configuration PEC and holds each byte in the output register.
// ----------------------------------------------------------------------------
module cfpg_back
	import cfpg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] frame_byte,
	output logic       last_byte
);

	seq_state_t  state_q;
	seq_state_t  state_d;
	seq_state_t  seq_next;
	logic        addressed_q;
	logic [1:0]  addr_q;
	logic [11:0] mask_q;
	logic [7:0]  crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        advance;
	logic        take_req;
	logic [7:0]  byte_d;
	logic        last_d;
	logic        crc_en;
	logic [7:0]  crc_base;
	logic [7:0]  addr_byte;

	assign advance   = (state_q != SEQ_IDLE) & (~out_valid_q | pop);
	assign addr_byte = ADDR_BASE + {6'b0, addr_q};
	assign crc_base  = (state_q == SEQ_MODE) ? PEC_SEED : crc_q;
	assign take_req  = req_valid & req_ready;

	always_comb begin
		byte_d    = ZERO_BYTE;
		last_d    = 1'b0;
		crc_en    = 1'b0;
		seq_next  = state_q;
		req_ready = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				req_ready = 1'b1;
				seq_next  = req_valid ? SEQ_CMD : SEQ_IDLE;
			end
			SEQ_CMD: begin
				byte_d   = cfg.write_command_code;
				seq_next = SEQ_CMD_PEC;
			end
			SEQ_CMD_PEC: begin
				byte_d   = pec_update(PEC_SEED, cfg.write_command_code);
				seq_next = addressed_q ? SEQ_ADDR : SEQ_MODE;
			end
			SEQ_ADDR: begin
				byte_d   = addr_byte;
				seq_next = SEQ_ADDR_PEC;
			end
			SEQ_ADDR_PEC: begin
				byte_d   = pec_update(PEC_SEED, addr_byte);
				seq_next = SEQ_MODE;
			end
			SEQ_MODE: begin
				byte_d   = cfg.mode_byte;
				crc_en   = 1'b1;
				seq_next = SEQ_MASK_LO;
			end
			SEQ_MASK_LO: begin
				byte_d   = mask_q[7:0];
				crc_en   = 1'b1;
				seq_next = SEQ_MASK_HI;
			end
			SEQ_MASK_HI: begin
				byte_d   = {4'b0, mask_q[11:8]};
				crc_en   = 1'b1;
				seq_next = SEQ_ZERO;
			end
			SEQ_ZERO: begin
				byte_d   = ZERO_BYTE;
				crc_en   = 1'b1;
				seq_next = SEQ_UNDERVOLT;
			end
			SEQ_UNDERVOLT: begin
				byte_d   = cfg.undervolt_code;
				crc_en   = 1'b1;
				seq_next = SEQ_OVERVOLT;
			end
			SEQ_OVERVOLT: begin
				byte_d   = cfg.overvolt_code;
				crc_en   = 1'b1;
				seq_next = SEQ_PEC;
			end
			SEQ_PEC: begin
				byte_d    = crc_q;
				last_d    = 1'b1;
				req_ready = advance;
				seq_next  = req_valid ? SEQ_CMD : SEQ_IDLE;
			end
			default: begin
				seq_next = SEQ_IDLE;
			end
		endcase
		if (state_q == SEQ_IDLE || advance) begin
			state_d = seq_next;
		end else begin
			state_d = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			addressed_q <= req.addressed;
			addr_q      <= req.board_address;
			mask_q      <= req.discharge_mask;
		end
		if (advance) begin
			out_byte_q <= byte_d;
			out_last_q <= last_d;
			if (crc_en) begin
				crc_q <= pec_update(crc_base, byte_d);
			end
		end
	end

	assign empty      = ~out_valid_q;
	assign frame_byte = out_byte_q;
	assign last_byte  = out_last_q;

endmodule

[design/config_frame_pec_generator_core.sv]
// ----------------------------------------------------------------------------
// config_frame_pec_generator_core
// Builds the write-configuration byte frame with PEC bytes for a cell-monitor
// chip from a board address and a cell discharge map.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// request   in         push / full             board_address, discharge_mask
// frame     out        empty / pop             frame_byte, last_byte
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A request yields 11 frame bytes for an addressed board and 9 for a
// broadcast, one byte per cycle from the sequencer while the output register
// is popped or empty; the next waiting request is taken as the closing PEC
// byte moves out, and one that finds the sequencer idle is taken in SEQ_IDLE.
// The request queue holds REQ_DEPTH requests. Reset empties the queue and the
// output register, idles the sequencer and loads the registers with defaults.
// ----------------------------------------------------------------------------
module config_frame_pec_generator_core
	import cfpg_pkg::*;
#(
	parameter int unsigned REQ_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [1:0]             board_address,
	input  logic [11:0]            discharge_mask,
	output logic                   empty,
	input  logic                   pop,
	output logic [7:0]             frame_byte,
	output logic                   last_byte,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	cfg_t cfg_q;
	logic req_valid;
	logic req_ready;
	req_t req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_command_code <= 8'h01;
			cfg_q.mode_byte          <= 8'h00;
			cfg_q.undervolt_code     <= 8'h00;
			cfg_q.overvolt_code      <= 8'h00;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_WRITE_COMMAND: cfg_q.write_command_code <= cfg_data;
				REG_MODE:          cfg_q.mode_byte          <= cfg_data;
				REG_UNDERVOLT:     cfg_q.undervolt_code     <= cfg_data;
				REG_OVERVOLT:      cfg_q.overvolt_code      <= cfg_data;
				default:           cfg_q                    <= cfg_q;
			endcase
		end
	end

	cfpg_front #(
		.DEPTH(REQ_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.board_address (board_address),
		.discharge_mask(discharge_mask),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req)
	);

	cfpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.frame_byte(frame_byte),
		.last_byte (last_byte)
	);

endmodule

[design/cfpg_checker.sv]
// ----------------------------------------------------------------------------
// cfpg_checker
// Port-level checks of the configuration frame generator, bound to the top
// level.
// ----------------------------------------------------------------------------
module cfpg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] frame_byte,
	input logic       last_byte,
	input logic       cfg_ready
);

	logic [3:0] byte_cnt_q;
	logic       out_xfer;

	assign out_xfer = pop & ~empty;

	// Counts the bytes transferred since the last closing PEC byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
		end else if (out_xfer) begin
			byte_cnt_q <= last_byte ? 4'd0 : byte_cnt_q + 1'b1;
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(last_byte)))
		else $error("waiting result changed or vanished before its transfer");

	a_frame_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && last_byte) |-> (byte_cnt_q == 4'd8 || byte_cnt_q == 4'd10))
		else $error("frame closed after a wrong number of bytes");

	a_frame_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !last_byte) |-> (byte_cnt_q < 4'd10))
		else $error("frame ran past its longest length");

	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> (empty && !full && cfg_ready))
		else $error("queue not empty or not ready right after reset");

endmodule

bind config_frame_pec_generator_core cfpg_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.frame_byte(frame_byte),
	.last_byte (last_byte),
	.cfg_ready (cfg_ready)
);
